/* hw/rtl/ffea_pkg.sv */
// ffea_pkg: shared types, codes and helpers of the first-fit extent allocator
// no dependencies; imported by first_fit_extent_allocator_unit

package ffea_pkg;

    // fixed field widths
    localparam int OFF_W  = 24;
    localparam int REQ_W  = 28;
    localparam int NEED_W = REQ_W + 1;
    localparam int SUM_W  = OFF_W + 2;

    localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};

    // operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_NO_FIT = 2'd1,
        STAT_FULL   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SCAN,
        S_EVAL,
        S_SHDN,
        S_SHUP
    } state_t;

    // request transfer
    typedef struct packed {
        logic             func;
        logic [REQ_W-1:0] req_bytes;
        logic [OFF_W-1:0] block_offset;
        logic [OFF_W-1:0] block_units;
    } req_t;

    // result transfer
    typedef struct packed {
        status_t          status;
        logic [OFF_W-1:0] granted_offset;
        logic [OFF_W-1:0] granted_units;
    } rsp_t;

    // one free table entry
    typedef struct packed {
        logic [OFF_W-1:0] off;
        logic [OFF_W-1:0] size;
    } ext_t;

    // clamp a merged size to the largest offset value
    function automatic logic [OFF_W-1:0] sat_size(input logic [SUM_W-1:0] v);
        if (v > SUM_W'(OFF_MAX))
            return OFF_MAX;
        else
            return v[OFF_W-1:0];
    endfunction

    // data size of the single extent covering a whole pool
    function automatic logic [OFF_W-1:0] pool_size(input logic [OFF_W-1:0] p);
        if (p == '0)
            return '0;
        else
            return p - 1'b1;
    endfunction

endpackage

/* hw/rtl/first_fit_extent_allocator_unit.sv */
// first_fit_extent_allocator_unit: address-ordered first-fit allocator with coalescing
// depends on ffea_pkg; free table held in one synchronous memory inside this module
//
//  channel   ports                          transfer
//  -------   -----------------------------  ---------------------------------------
//  request   start, busy, req               start high and busy low at a clock edge
//  result    done, rsp                      done high for one cycle, always taken
//  config    cfg_we, cfg_wdata              cfg_we high at a clock edge
//
// sequence: busy through a scan to the slot found (the entry count when nothing
//   matches) and an evaluate step; an exact fit or a two-sided merge then shifts
//   later entries down to close the gap, and an insert shifts entries up to open a slot.
// the result strobe follows in the first idle cycle; request units come from a shift
//   by the header size, which must be a power of two; the block does not enforce it.
// after reset the block writes the first table entry in its init state (busy high).
// a pool_units write rebuilds the table at once; the receiver cannot stall results.

module first_fit_extent_allocator_unit #(
    parameter int HEADER_BYTES = 16,
    parameter int TABLE_DEPTH  = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  ffea_pkg::req_t                 req,
    output logic                           done,
    output ffea_pkg::rsp_t                 rsp,
    input  logic                           cfg_we,
    input  logic [ffea_pkg::OFF_W-1:0]     cfg_wdata
);
    import ffea_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int HB_SH  = $clog2(HEADER_BYTES);

    localparam logic [CNT_W-1:0]  DEPTH_C  = CNT_W'(TABLE_DEPTH);

    // free table memory
    ext_t             ext_mem [TABLE_DEPTH];
    ext_t             rdata_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    ext_t             mem_wdata;

    // control registers
    state_t           state_reg, state_next;
    logic [OFF_W-1:0] pool_reg, pool_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             chk_vld_reg, chk_vld_next;
    logic             prev_vld_reg, prev_vld_next;
    logic             hit_vld_reg, hit_vld_next;

    // payload registers
    logic              func_reg, func_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    ext_t              prev_reg, prev_next;
    ext_t              hit_reg, hit_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    rsp_t              rsp_reg, rsp_next;

    // scan and shift decisions
    logic             fwd_issue;
    logic             back_issue;
    logic             scan_match;
    logic             fwd_end;
    logic             back_end;

    // evaluation of the slot found
    logic [OFF_W-1:0] units24;
    logic             is_alloc;
    logic             alloc_split;
    logic [SUM_W-1:0] prev_end;
    logic [SUM_W-1:0] free_end;
    logic             adj_prev;
    logic             adj_next;
    logic [SUM_W-1:0] sum_prev;
    logic [SUM_W-1:0] sum_next;
    logic [SUM_W-1:0] sum_both;
    logic             eval_shdn;
    logic             eval_shup;

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // forward walk (scan, shift down) and backward walk (shift up)
    assign fwd_issue  = (idx_reg < count_reg);
    assign back_issue = (idx_reg > pos_reg);
    assign fwd_end    = !chk_vld_reg && !fwd_issue;
    assign back_end   = !chk_vld_reg && !back_issue;
    assign is_alloc   = (func_reg == FUNC_ALLOC);
    assign scan_match = chk_vld_reg &&
                        (is_alloc ? ({{(NEED_W-OFF_W){1'b0}}, rdata_reg.size} >= need_reg)
                                  : (rdata_reg.off >= off_reg));

    // split or exact fit, adjacency and merged sizes
    assign units24     = need_reg[OFF_W-1:0];
    assign alloc_split = ({{(NEED_W-OFF_W){1'b0}}, hit_reg.size} > need_reg);
    assign prev_end    = SUM_W'(prev_reg.off) + SUM_W'(1) + SUM_W'(prev_reg.size);
    assign free_end    = SUM_W'(off_reg) + SUM_W'(1) + SUM_W'(units24);
    assign adj_prev    = prev_vld_reg && (prev_end == SUM_W'(off_reg));
    assign adj_next    = hit_vld_reg && (free_end == SUM_W'(hit_reg.off));
    assign sum_prev    = SUM_W'(prev_reg.size) + SUM_W'(1) + SUM_W'(units24);
    assign sum_next    = SUM_W'(hit_reg.size) + SUM_W'(1) + SUM_W'(units24);
    assign sum_both    = SUM_W'(prev_reg.size) + SUM_W'(hit_reg.size) +
                         SUM_W'(units24) + SUM_W'(2);
    assign eval_shdn   = is_alloc ? (hit_vld_reg && !alloc_split) : (adj_prev && adj_next);
    assign eval_shup   = !is_alloc && !adj_prev && !adj_next && (count_reg < DEPTH_C);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_match || fwd_end)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                priority if (eval_shdn)
                    state_next = S_SHDN;
                else if (eval_shup)
                    state_next = S_SHUP;
                else
                    state_next = S_IDLE;
            end
            S_SHDN:
            begin
                if (fwd_end)
                    state_next = S_IDLE;
            end
            S_SHUP:
            begin
                if (back_end)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        pool_next     = pool_reg;
        count_next    = count_reg;
        done_next     = 1'b0;
        idx_next      = idx_reg;
        chk_vld_next  = chk_vld_reg;
        prev_vld_next = prev_vld_reg;
        hit_vld_next  = hit_vld_reg;
        func_next     = func_reg;
        need_next     = need_reg;
        off_next      = off_reg;
        chk_idx_next  = chk_idx_reg;
        prev_next     = prev_reg;
        hit_next      = hit_reg;
        pos_next      = pos_reg;
        rsp_next      = rsp_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_raddr     = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_INIT:
            begin
                mem_we         = 1'b1;
                mem_wdata.off  = '0;
                mem_wdata.size = pool_size(pool_reg);
            end
            S_IDLE:
            begin
                if (start)
                begin
                    // allocate: whole header units below the byte count, plus one
                    func_next     = req.func;
                    need_next     = (req.func == FUNC_ALLOC) ?
                                    NEED_W'(req.req_bytes >> HB_SH) + NEED_W'(1) :
                                    NEED_W'(req.block_units);
                    off_next      = req.block_offset;
                    idx_next      = '0;
                    chk_vld_next  = 1'b0;
                    prev_vld_next = 1'b0;
                    hit_vld_next  = 1'b0;
                end
            end
            S_SCAN:
            begin
                // one read issued per cycle, the previous read checked
                if (fwd_issue)
                    idx_next = idx_reg + 1'b1;
                chk_vld_next = fwd_issue;
                chk_idx_next = idx_reg[IDX_W-1:0];
                if (chk_vld_reg)
                begin
                    if (scan_match)
                    begin
                        pos_next     = CNT_W'(chk_idx_reg);
                        hit_next     = rdata_reg;
                        hit_vld_next = 1'b1;
                    end
                    else
                    begin
                        prev_next     = rdata_reg;
                        prev_vld_next = 1'b1;
                    end
                end
                else if (!fwd_issue)
                begin
                    pos_next     = count_reg;
                    hit_vld_next = 1'b0;
                end
            end
            S_EVAL:
            begin
                rsp_next.status         = STAT_OK;
                rsp_next.granted_offset = '0;
                rsp_next.granted_units  = '0;
                chk_vld_next            = 1'b0;
                if (is_alloc)
                begin
                    if (!hit_vld_reg)
                    begin
                        rsp_next.status = STAT_NO_FIT;
                        done_next       = 1'b1;
                    end
                    else
                    begin
                        rsp_next.granted_offset = hit_reg.off;
                        rsp_next.granted_units  = units24;
                        if (alloc_split)
                        begin
                            // remainder stays in the same slot
                            mem_we         = 1'b1;
                            mem_waddr      = pos_reg[IDX_W-1:0];
                            mem_wdata.off  = hit_reg.off + 1'b1 + units24;
                            mem_wdata.size = hit_reg.size - units24 - 1'b1;
                            done_next      = 1'b1;
                        end
                        else
                        begin
                            idx_next = pos_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    priority if (adj_prev && adj_next)
                    begin
                        mem_we         = 1'b1;
                        mem_waddr      = IDX_W'(pos_reg - 1'b1);
                        mem_wdata.off  = prev_reg.off;
                        mem_wdata.size = sat_size(sum_both);
                        idx_next       = pos_reg + 1'b1;
                    end
                    else if (adj_prev)
                    begin
                        mem_we         = 1'b1;
                        mem_waddr      = IDX_W'(pos_reg - 1'b1);
                        mem_wdata.off  = prev_reg.off;
                        mem_wdata.size = sat_size(sum_prev);
                        done_next      = 1'b1;
                    end
                    else if (adj_next)
                    begin
                        mem_we         = 1'b1;
                        mem_waddr      = pos_reg[IDX_W-1:0];
                        mem_wdata.off  = off_reg;
                        mem_wdata.size = sat_size(sum_next);
                        done_next      = 1'b1;
                    end
                    else if (count_reg >= DEPTH_C)
                    begin
                        rsp_next.status = STAT_FULL;
                        done_next       = 1'b1;
                    end
                    else
                    begin
                        idx_next = count_reg;
                    end
                end
            end
            S_SHDN:
            begin
                // close the gap: read ahead, write one slot lower
                if (fwd_issue)
                    idx_next = idx_reg + 1'b1;
                chk_vld_next = fwd_issue;
                chk_idx_next = idx_reg[IDX_W-1:0];
                if (chk_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = chk_idx_reg - 1'b1;
                    mem_wdata = rdata_reg;
                end
                if (fwd_end)
                begin
                    count_next = count_reg - 1'b1;
                    done_next  = 1'b1;
                end
            end
            S_SHUP:
            begin
                // open a slot: read from the top down, write one slot higher
                mem_raddr = IDX_W'(idx_reg - 1'b1);
                if (back_issue)
                    idx_next = idx_reg - 1'b1;
                chk_vld_next = back_issue;
                chk_idx_next = IDX_W'(idx_reg - 1'b1);
                if (chk_vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = chk_idx_reg + 1'b1;
                    mem_wdata = rdata_reg;
                end
                else if (!back_issue)
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = pos_reg[IDX_W-1:0];
                    mem_wdata.off  = off_reg;
                    mem_wdata.size = units24;
                    count_next     = count_reg + 1'b1;
                    done_next      = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // pool write rebuilds the table as one extent
        if (cfg_we)
        begin
            pool_next      = cfg_wdata;
            count_next     = CNT_W'(1);
            mem_we         = 1'b1;
            mem_waddr      = '0;
            mem_wdata.off  = '0;
            mem_wdata.size = pool_size(cfg_wdata);
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            pool_reg     <= OFF_MAX;
            count_reg    <= CNT_W'(1);
            done_reg     <= 1'b0;
            idx_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            prev_vld_reg <= 1'b0;
            hit_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pool_reg     <= pool_next;
            count_reg    <= count_next;
            done_reg     <= done_next;
            idx_reg      <= idx_next;
            chk_vld_reg  <= chk_vld_next;
            prev_vld_reg <= prev_vld_next;
            hit_vld_reg  <= hit_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        need_reg    <= need_next;
        off_reg     <= off_next;
        chk_idx_reg <= chk_idx_next;
        prev_reg    <= prev_next;
        hit_reg     <= hit_next;
        pos_reg     <= pos_next;
        rsp_reg     <= rsp_next;
    end

    // table memory, reads run ahead of writes so no entry is read and written together
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ext_mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= ext_mem[mem_raddr];
    end

    // an accepted request keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request transfer did not make the block busy");

    // a result only follows work in progress
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result transfer without a request in progress");

    // an operation moves the entry count by at most one and never past the depth
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> (count_reg <= DEPTH_C) &&
                    (count_reg == $past(count_reg) ||
                     count_reg == CNT_W'($past(count_reg) + 1'b1) ||
                     count_reg == CNT_W'($past(count_reg) - 1'b1)))
        else $error("free table count changed by more than one entry");

    // a failed allocate grants nothing
    a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == STAT_NO_FIT) |->
            (func_reg == FUNC_ALLOC && rsp.granted_offset == '0 && rsp.granted_units == '0))
        else $error("no-fit result carries a grant");

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// testbench: self-checking bench for first_fit_extent_allocator_unit with its own free table
// predictor; depends on ffea_pkg and the allocator RTL only

module testbench;

    import ffea_pkg::*;

    localparam int HEADER_BYTES   = 16;
    localparam int TABLE_DEPTH    = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 200;
    localparam longint unsigned LEN_CEIL = 64'h0000_0000_00FF_FFFF;

    // one extent handed out by an allocate
    typedef struct packed {
        logic [OFF_W-1:0] off;
        logic [OFF_W-1:0] units;
    } grant_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             start     = 1'b0;
    logic             busy;
    req_t             req       = '0;
    logic             done;
    rsp_t             rsp;
    logic             cfg_we    = 1'b0;
    logic [OFF_W-1:0] cfg_wdata = '0;

    // predicted free table
    logic [OFF_W-1:0] free_off [TABLE_DEPTH];
    logic [OFF_W-1:0] free_len [TABLE_DEPTH];
    int               free_entries;

    rsp_t        awaited_rsp [$];
    grant_t      held_grants [$];
    rsp_t        want_rsp;
    int          burst_left;
    bit          back_to_back;
    int unsigned mismatches;
    int unsigned n_checked;
    int unsigned n_alloc;
    int unsigned n_free;
    int unsigned n_granted;
    int unsigned n_no_fit;
    int unsigned n_full;
    int unsigned n_pools;
    int unsigned idle_cycles;

    first_fit_extent_allocator_unit #(
        .HEADER_BYTES(HEADER_BYTES),
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // free table predictor
    // ------------------------------------------------------------------

    // merged sizes stick at the largest offset value
    function automatic logic [OFF_W-1:0] clamp_len(input longint unsigned v);
        if (v > LEN_CEIL)
            return OFF_MAX;
        return OFF_W'(v);
    endfunction

    // whole pool as a single extent at offset 0
    function automatic void rebuild_free_table(input logic [OFF_W-1:0] units);
        foreach (free_off[i])
        begin
            free_off[i] = '0;
            free_len[i] = '0;
        end
        free_len[0]  = (units == '0) ? '0 : units - 1'b1;
        free_entries = 1;
    endfunction

    // close the gap left by entry idx
    function automatic void drop_free_entry(input int idx);
        int k;
        for (k = idx; k + 1 < free_entries; k++)
        begin
            free_off[k] = free_off[k + 1];
            free_len[k] = free_len[k + 1];
        end
        free_entries--;
    endfunction

    // first fit: split the entry or take it whole
    function automatic rsp_t carve_extent(input logic [REQ_W-1:0] bytes);
        rsp_t            res;
        longint unsigned need;
        int              i;
        res        = '0;
        res.status = STAT_NO_FIT;
        need       = bytes;
        need       = need / HEADER_BYTES + 1;
        for (i = 0; i < free_entries; i++)
        begin
            if (free_len[i] >= need)
            begin
                res.status         = STAT_OK;
                res.granted_offset = free_off[i];
                res.granted_units  = OFF_W'(need);
                if (free_len[i] > need)
                begin
                    // remainder starts past the new header and its data, wrapping at the width
                    free_off[i] = free_off[i] + OFF_W'(need) + 1'b1;
                    free_len[i] = free_len[i] - OFF_W'(need) - 1'b1;
                end
                else
                    drop_free_entry(i);
                break;
            end
        end
        return res;
    endfunction

    // coalesce with the lower and upper neighbor, else an address-ordered insert
    function automatic rsp_t return_extent(input logic [OFF_W-1:0] off,
                                           input logic [OFF_W-1:0] units);
        rsp_t            res;
        int              p;
        int              k;
        bit              joins_lower;
        bit              joins_upper;
        longint unsigned lower_end;
        longint unsigned upper_start;
        longint unsigned merged;
        res         = '0;
        res.status  = STAT_OK;
        joins_lower = 1'b0;
        p           = 0;
        while (p < free_entries && free_off[p] < off)
            p++;
        if (p > 0)
        begin
            lower_end   = free_off[p - 1];
            lower_end   = lower_end + free_len[p - 1] + 1;
            joins_lower = (lower_end == off);
        end
        upper_start = off;
        upper_start = upper_start + units + 1;
        joins_upper = (p < free_entries) && (upper_start == free_off[p]);
        if (joins_lower && joins_upper)
        begin
            merged            = free_len[p - 1];
            merged            = merged + units + free_len[p] + 2;
            free_len[p - 1]   = clamp_len(merged);
            drop_free_entry(p);
        end
        else if (joins_lower)
        begin
            merged          = free_len[p - 1];
            merged          = merged + units + 1;
            free_len[p - 1] = clamp_len(merged);
        end
        else if (joins_upper)
        begin
            merged      = free_len[p];
            merged      = merged + units + 1;
            free_off[p] = off;
            free_len[p] = clamp_len(merged);
        end
        else if (free_entries >= TABLE_DEPTH)
            res.status = STAT_FULL;
        else
        begin
            for (k = free_entries; k > p; k--)
            begin
                free_off[k] = free_off[k - 1];
                free_len[k] = free_len[k - 1];
            end
            free_off[p] = off;
            free_len[p] = units;
            free_entries++;
        end
        return res;
    endfunction

    function automatic rsp_t predict_outcome(input req_t item);
        if (item.func == FUNC_ALLOC)
            return carve_extent(item.req_bytes);
        return return_extent(item.block_offset, item.block_units);
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    function automatic void compare_field(input string label, input logic [OFF_W-1:0] want,
                                          input logic [OFF_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t %s mismatch: expected %0d, got %0d", $time, label, want, got);
        end
    endfunction

    // every result transfer is matched against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (awaited_rsp.size() == 0)
            begin
                mismatches++;
                $display("%0t result with nothing pending: expected none, got %0d/%0d/%0d",
                         $time, rsp.status, rsp.granted_offset, rsp.granted_units);
            end
            else
            begin
                want_rsp = awaited_rsp.pop_front();
                n_checked++;
                compare_field("status", OFF_W'(want_rsp.status), OFF_W'(rsp.status));
                compare_field("granted_offset", want_rsp.granted_offset, rsp.granted_offset);
                compare_field("granted_units", want_rsp.granted_units, rsp.granted_units);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t watchdog: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // one request transfer, then a random gap at the end of a burst unless back to back
    task automatic send_request(input req_t item, output rsp_t outcome);
        int gap;
        @(negedge clk);
        start <= 1'b1;
        req   <= item;
        do @(posedge clk); while (busy);
        outcome = predict_outcome(item);
        awaited_rsp.push_back(outcome);
        if (item.func == FUNC_ALLOC)
            n_alloc++;
        else
            n_free++;
        case (outcome.status)
            STAT_OK:     if (item.func == FUNC_ALLOC) n_granted++;
            STAT_NO_FIT: n_no_fit++;
            STAT_FULL:   n_full++;
            default:     ;
        endcase
        if (!back_to_back)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                gap = $urandom_range(1, 40);
                @(negedge clk);
                start <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    task automatic request_alloc(input logic [REQ_W-1:0] bytes);
        req_t item;
        rsp_t outcome;
        item              = '0;
        item.func         = FUNC_ALLOC;
        item.req_bytes    = bytes;
        item.block_offset = OFF_W'($urandom());
        item.block_units  = OFF_W'($urandom());
        send_request(item, outcome);
    endtask

    task automatic request_free(input logic [OFF_W-1:0] off, input logic [OFF_W-1:0] units);
        req_t item;
        rsp_t outcome;
        item              = '0;
        item.func         = FUNC_FREE;
        item.req_bytes    = REQ_W'($urandom());
        item.block_offset = off;
        item.block_units  = units;
        send_request(item, outcome);
    endtask

    // hold the sender until every predicted result has been seen
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        do @(posedge clk); while (awaited_rsp.size() != 0 || busy);
    endtask

    // pool size write, only with the block idle
    task automatic program_pool(input logic [OFF_W-1:0] units);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= units;
        @(posedge clk);
        rebuild_free_table(units);
        n_pools++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // reset pool: oversize request, exact fit of the whole pool, size saturation
    task automatic test_pool_limits();
        request_alloc(28'hFFF_FFFF);
        request_alloc(28'd268435423);
        request_alloc(28'd0);
        request_free(24'd0, 24'd16777214);
        request_alloc(28'd0);
        request_free(24'd0, 24'd1);
        request_free(24'hFF_FFFF, 24'hFF_FFFF);
        request_alloc(28'hFFF_FFFF);
        request_alloc(28'd268435439);
    endtask

    // pools of two, one and zero units
    task automatic test_small_pools();
        program_pool(24'd2);
        request_alloc(28'd0);
        request_alloc(28'd0);
        request_free(24'd0, 24'd1);
        program_pool(24'd1);
        request_alloc(28'd0);
        request_free(24'd5, 24'd0);
        request_alloc(28'd15);
        program_pool(24'd0);
        request_alloc(28'd0);
    endtask

    // insert, merge upward, merge downward and merge on both sides
    task automatic test_coalescing();
        program_pool(24'd100);
        request_alloc(28'd40);
        request_alloc(28'd40);
        request_alloc(28'd40);
        request_free(24'd4, 24'd3);
        request_free(24'd8, 24'd3);
        request_free(24'd0, 24'd3);
        request_alloc(28'd40);
        request_alloc(28'd40);
        request_alloc(28'd40);
        request_free(24'd0, 24'd3);
        request_free(24'd4, 24'd3);
    endtask

    // fill the table with isolated extents, then frees with and without a merge
    task automatic test_table_full();
        int k;
        program_pool(OFF_MAX);
        for (k = 63; k >= 1; k--)
            request_free(OFF_W'(k * 1000), 24'd0);
        request_free(24'd1001, 24'd0);
        request_free(24'd500, 24'd0);
        request_free(24'd1002, 24'd997);
        request_free(24'd500, 24'd0);
        request_alloc(28'd0);
    endtask

    // allocate and free sequences with stray and repeated frees mixed in
    task automatic test_random_traffic(input int phases, input int per_phase);
        req_t             item;
        rsp_t             outcome;
        grant_t           held;
        logic [OFF_W-1:0] pool;
        int unsigned      span;
        int               ph;
        int               n;
        int               roll;
        int               pick;
        for (ph = 0; ph < phases; ph++)
        begin
            case (ph % 4)
                0:       pool = OFF_MAX;
                1:       pool = 24'd2;
                2:       pool = OFF_W'($urandom());
                default: pool = OFF_W'($urandom_range(16, 4000));
            endcase
            held_grants.delete();
            program_pool(pool);
            back_to_back = ($urandom_range(0, 3) == 0);
            span         = (pool >> 3) + 1;
            for (n = 0; n < per_phase; n++)
            begin
                roll              = $urandom_range(0, 99);
                item.req_bytes    = REQ_W'($urandom());
                item.block_offset = OFF_W'($urandom());
                item.block_units  = OFF_W'($urandom());
                if (roll < 50 || held_grants.size() == 0)
                begin
                    item.func = FUNC_ALLOC;
                    roll      = $urandom_range(0, 9);
                    if (roll >= 1 && roll < 5)
                        item.req_bytes = REQ_W'($urandom_range(0, 47));
                    else if (roll >= 5)
                        item.req_bytes = REQ_W'($urandom_range(0, span * 16));
                end
                else if (roll < 94)
                begin
                    item.func = FUNC_FREE;
                    pick      = $urandom_range(0, held_grants.size() - 1);
                    held      = held_grants[pick];
                    // a stray extent keeps its random fields
                    if (roll < 88 || roll >= 91)
                    begin
                        item.block_offset = held.off;
                        item.block_units  = held.units;
                    end
                    // a repeated free leaves the extent in the held list
                    if (roll < 88)
                        held_grants.delete(pick);
                end
                else
                    item.func = FUNC_FREE;
                send_request(item, outcome);
                if (item.func == FUNC_ALLOC && outcome.status == STAT_OK)
                    held_grants.push_back('{outcome.granted_offset, outcome.granted_units});
                if (ph % 2 == 1 && n == per_phase / 2)
                    drain_results();
            end
        end
    endtask

    initial
    begin
        mismatches   = 0;
        n_checked    = 0;
        n_alloc      = 0;
        n_free       = 0;
        n_granted    = 0;
        n_no_fit     = 0;
        n_full       = 0;
        n_pools      = 0;
        back_to_back = 1'b0;
        burst_left   = $urandom_range(1, 24);
        rebuild_free_table(OFF_MAX);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_pool_limits();
        test_small_pools();
        test_coalescing();
        test_table_full();
        test_random_traffic(6, 150);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d pool settings, %0d allocate and %0d free requests, %0d results checked",
                 n_pools, n_alloc, n_free, n_checked);
        $display("outcomes: %0d grants, %0d without a fitting extent, %0d frees dropped on a full table",
                 n_granted, n_no_fit, n_full);
        if (mismatches == 0 && awaited_rsp.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
